// ===== rtl/hfs_pkg.sv =====
package hfs_pkg;

    localparam int MAP_DEPTH = 1024;
    localparam int AW        = $clog2(MAP_DEPTH);   // map entry address
    localparam int CNT_W     = AW + 1;              // counts 0..MAP_DEPTH

    localparam int IDX_W     = 10;                  // map_index field
    localparam int SIZE_W    = 11;                  // request_size / use_size
    localparam int ADDR_W    = 16;                  // absolute addresses
    localparam int STRAT_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DW    = 16;
    localparam int S_DATA_W  = 24;                  // 22 bits of fields, byte padded
    localparam int M_DATA_W  = 16;

    localparam logic [STRAT_W-1:0] STRAT_FIRST = 2'd0;
    localparam logic [STRAT_W-1:0] STRAT_NEXT  = 2'd1;
    localparam logic [STRAT_W-1:0] STRAT_BEST  = 2'd2;
    localparam logic [STRAT_W-1:0] STRAT_WORST = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_STRATEGY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_START = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_SIZE  = 2'd2;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_SCAN   = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

endpackage

// ===== rtl/heap_fit_strategy_search.sv =====
// Write beat: map entry written at the accept edge, no result; one item at a time.
// Search beat: reads one map entry per cycle (1-bit memory, registered read) over an area
//   of n = min(use_size, MAP_DEPTH) entries; first/next fit stop at a hit, a zero or oversized
//   size skips the scan, and a next fit miss past the pointer scans again from entry 0.
// A result may wait in the output register while the next item is taken.
// Sync active-low reset, then a pass clears all map entries with input tready held low.
module heap_fit_strategy_search (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // config write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [hfs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hfs_pkg::CFG_DW-1:0]     i_cfg_data,
    // input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [hfs_pkg::S_DATA_W-1:0]   s_axis_tdata,  // [9:0] map_index, [10] used_flag,
                                                          // [21:11] request_size, [23:22] zero
    input  logic                           s_axis_tuser,  // [0] kind
    // result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [hfs_pkg::M_DATA_W-1:0]   m_axis_tdata,  // [15:0] alloc_address
    output logic                           m_axis_tuser   // [0] found
);

    localparam int AW    = hfs_pkg::AW;
    localparam int CNT_W = hfs_pkg::CNT_W;

    // map memory
    logic                      r_map [hfs_pkg::MAP_DEPTH];
    logic                      r_rdata;
    logic                      mem_we;
    logic [AW-1:0]             mem_waddr;
    logic                      mem_wdata;

    // config
    logic [hfs_pkg::STRAT_W-1:0] r_strategy;
    logic [hfs_pkg::ADDR_W-1:0]  r_use_start;
    logic [hfs_pkg::SIZE_W-1:0]  r_use_size;

    // control and datapath
    hfs_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_clr, n_clr;
    logic [CNT_W-1:0] r_ptr, n_ptr;
    logic [CNT_W-1:0] r_iss, n_iss;       // next entry to read
    logic [CNT_W-1:0] r_pos, n_pos;       // entry whose data sits in r_rdata
    logic             r_dv, n_dv;
    logic             r_pass1, n_pass1;   // next fit, scan from the pointer
    logic [CNT_W-1:0] r_size, n_size;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_run_start, n_run_start;
    logic             r_have, n_have;
    logic [CNT_W-1:0] r_pick, n_pick;
    logic             r_res_found, n_res_found;
    logic [AW-1:0]    r_res_off, n_res_off;
    logic             r_out_valid, n_out_valid;
    logic             r_out_found, n_out_found;
    logic [hfs_pkg::ADDR_W-1:0] r_out_addr, n_out_addr;

    logic [CNT_W-1:0] area_len;
    logic             in_acc;
    logic [hfs_pkg::IDX_W-1:0]  in_index;
    logic                       in_used;
    logic [hfs_pkg::SIZE_W-1:0] in_size;
    logic             counting;
    logic             is_best;
    logic             last;
    logic [CNT_W-1:0] pos_p1;
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] start_cur;
    logic             run_end;
    logic [CNT_W-1:0] run_len;
    logic             qual;
    logic             hit;

    assign in_index = s_axis_tdata[9:0];
    assign in_used  = s_axis_tdata[10];
    assign in_size  = s_axis_tdata[21:11];

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == hfs_pkg::S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_addr;
    assign m_axis_tuser  = r_out_found;

    assign area_len = (32'(r_use_size) > 32'(hfs_pkg::MAP_DEPTH)) ?
                      CNT_W'(hfs_pkg::MAP_DEPTH) : CNT_W'(r_use_size);

    // first and next fit count free entries; best and worst judge whole runs
    assign counting  = (r_strategy == hfs_pkg::STRAT_FIRST) ||
                       (r_strategy == hfs_pkg::STRAT_NEXT);
    assign is_best   = (r_strategy == hfs_pkg::STRAT_BEST);
    assign pos_p1    = r_pos + CNT_W'(1);
    assign last      = (pos_p1 == area_len);
    assign cnt_inc   = r_count + CNT_W'(1);
    assign start_cur = (r_count == '0) ? r_pos : r_run_start;
    assign hit       = !r_rdata && (cnt_inc == r_size);
    assign run_end   = (r_rdata && (r_count != '0)) || (!r_rdata && last);
    assign run_len   = r_rdata ? r_count : cnt_inc;
    assign qual      = run_end && (run_len >= r_size) &&
                       (!r_have || (is_best ? (run_len <= r_pick) : (run_len >= r_pick)));

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_ptr       = r_ptr;
        n_iss       = r_iss;
        n_pos       = r_iss;
        n_dv        = 1'b0;
        n_pass1     = r_pass1;
        n_size      = r_size;
        n_count     = r_count;
        n_run_start = r_run_start;
        n_have      = r_have;
        n_pick      = r_pick;
        n_res_found = r_res_found;
        n_res_off   = r_res_off;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_found = r_out_found;
        n_out_addr  = r_out_addr;
        mem_we      = 1'b0;
        mem_waddr   = r_clr;
        mem_wdata   = 1'b0;

        case (r_state)
            hfs_pkg::S_CLEAR: begin
                mem_we = 1'b1;
                n_clr  = r_clr + AW'(1);
                if (r_clr == AW'(hfs_pkg::MAP_DEPTH - 1)) begin
                    n_state = hfs_pkg::S_IDLE;
                end
            end
            hfs_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (s_axis_tuser == hfs_pkg::KIND_WRITE) begin
                        if (32'(in_index) < 32'(hfs_pkg::MAP_DEPTH)) begin
                            mem_we    = 1'b1;
                            mem_waddr = AW'(in_index);
                            mem_wdata = in_used;
                        end
                    end else begin
                        n_size      = CNT_W'(in_size);
                        n_count     = '0;
                        n_have      = 1'b0;
                        n_pick      = '0;
                        n_res_found = 1'b0;
                        n_res_off   = '0;
                        if ((in_size == '0) || (32'(in_size) > 32'(area_len))) begin
                            n_state = hfs_pkg::S_FINISH;
                        end else begin
                            n_state = hfs_pkg::S_SCAN;
                            if ((r_strategy == hfs_pkg::STRAT_NEXT) && (r_ptr < area_len)) begin
                                n_iss   = r_ptr;
                                n_pass1 = 1'b1;
                            end else begin
                                n_iss   = '0;
                                n_pass1 = 1'b0;
                            end
                        end
                    end
                end
            end
            hfs_pkg::S_SCAN: begin
                n_dv = (r_iss < area_len);
                if (n_dv) begin
                    n_iss = r_iss + CNT_W'(1);
                end
                if (r_dv) begin
                    n_count = r_rdata ? '0 : cnt_inc;
                    if (!r_rdata && (r_count == '0)) begin
                        n_run_start = r_pos;
                    end
                    if (counting) begin
                        if (hit) begin
                            n_res_found = 1'b1;
                            n_res_off   = AW'(pos_p1 - r_size);
                            if (r_pass1) begin
                                n_ptr = pos_p1;
                            end
                            n_state = hfs_pkg::S_FINISH;
                            n_dv    = 1'b0;
                        end else if (last) begin
                            n_dv = 1'b0;
                            if (r_pass1) begin
                                // nothing after the pointer: first fit from the start
                                n_pass1 = 1'b0;
                                n_iss   = '0;
                                n_count = '0;
                            end else begin
                                n_state = hfs_pkg::S_FINISH;
                            end
                        end
                    end else begin
                        if (qual) begin
                            n_have    = 1'b1;
                            n_pick    = run_len;
                            n_res_off = AW'(start_cur);
                        end
                        if (last) begin
                            n_res_found = r_have || qual;
                            n_state     = hfs_pkg::S_FINISH;
                            n_dv        = 1'b0;
                        end
                    end
                end
            end
            hfs_pkg::S_FINISH: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_res_found;
                    n_out_addr  = r_res_found ?
                                  (r_use_start + hfs_pkg::ADDR_W'(r_res_off)) : '0;
                    n_state     = hfs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = hfs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_map[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_map[r_iss[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hfs_pkg::S_CLEAR;
            r_clr       <= '0;
            r_ptr       <= '0;
            r_dv        <= 1'b0;
            r_pass1     <= 1'b0;
            r_out_valid <= 1'b0;
            r_strategy  <= hfs_pkg::STRAT_FIRST;
            r_use_start <= '0;
            r_use_size  <= hfs_pkg::SIZE_W'(1024);
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_ptr       <= n_ptr;
            r_dv        <= n_dv;
            r_pass1     <= n_pass1;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    hfs_pkg::CFG_STRATEGY:  r_strategy  <= i_cfg_data[hfs_pkg::STRAT_W-1:0];
                    hfs_pkg::CFG_USE_START: r_use_start <= i_cfg_data[hfs_pkg::ADDR_W-1:0];
                    hfs_pkg::CFG_USE_SIZE:  r_use_size  <= i_cfg_data[hfs_pkg::SIZE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_iss       <= n_iss;
        r_pos       <= n_pos;
        r_size      <= n_size;
        r_count     <= n_count;
        r_run_start <= n_run_start;
        r_have      <= n_have;
        r_pick      <= n_pick;
        r_res_found <= n_res_found;
        r_res_off   <= n_res_off;
        r_out_found <= n_out_found;
        r_out_addr  <= n_out_addr;
    end

    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("not-found result with nonzero address");

    a_pos_in_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hfs_pkg::S_SCAN && r_dv) |-> (r_pos < area_len))
        else $error("scan processed an entry beyond the area");

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_ptr) <= 32'(hfs_pkg::MAP_DEPTH))
        else $error("next fit pointer out of range");

    a_run_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hfs_pkg::S_FINISH && r_res_found) |->
        ((32'(r_res_off) + 32'(r_size)) <= 32'(area_len)))
        else $error("chosen run runs past the area end");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hfs_pkg::S_FINISH && r_out_valid && !m_axis_tready) |=>
        (r_state == hfs_pkg::S_FINISH))
        else $error("result lost while output beat stalled");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int MAP_DEPTH   = hfs_pkg::MAP_DEPTH;
    localparam int IDX_W       = hfs_pkg::IDX_W;
    localparam int SIZE_W      = hfs_pkg::SIZE_W;
    localparam int ADDR_W      = hfs_pkg::ADDR_W;
    localparam int STRAT_W     = hfs_pkg::STRAT_W;

    typedef struct packed {
        logic              kind;
        logic [IDX_W-1:0]  map_index;
        logic              used_flag;
        logic [SIZE_W-1:0] request_size;
    } t_heap_op;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] addr;
    } t_alloc_result;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [hfs_pkg::CFG_IDX_W-1:0]   i_cfg_index = hfs_pkg::CFG_STRATEGY;
    logic [hfs_pkg::CFG_DW-1:0]      i_cfg_data = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [hfs_pkg::S_DATA_W-1:0]    s_axis_tdata = '0;
    logic                            s_axis_tuser = hfs_pkg::KIND_WRITE;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [hfs_pkg::M_DATA_W-1:0]    m_axis_tdata;
    logic                            m_axis_tuser;

    heap_fit_strategy_search dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // shadow of the block state
    bit                 heap_map [MAP_DEPTH];
    logic [SIZE_W-1:0]  nf_ptr = '0;
    logic [STRAT_W-1:0] fit_strategy = hfs_pkg::STRAT_FIRST;
    logic [ADDR_W-1:0]  area_base = '0;
    logic [SIZE_W-1:0]  area_words = 11'd1024;

    t_heap_op      op_pending_q [$];
    t_alloc_result alloc_expect_q [$];
    int            issued_cnt = 0;
    int            accepted_cnt = 0;
    int            mismatch_cnt = 0;
    int unsigned   cycle_cnt = 0;
    logic          in_fire = 1'b0;
    bit            steady = 1'b0;
    int            send_gap = 0;
    int            ready_gap = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH @%0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
        mismatch_cnt++;
    endtask

    // first/best/worst fit over maximal free runs of the area
    function automatic logic find_run(input logic [STRAT_W-1:0] mode, input int want,
                                      input int n, output int off);
        int   i;
        int   start;
        int   len;
        int   pick_len;
        logic have;
        i = 0;
        have = 1'b0;
        pick_len = 0;
        off = 0;
        while (i < n) begin
            if (heap_map[i]) begin
                i++;
            end else begin
                start = i;
                while (i < n && !heap_map[i]) i++;
                len = i - start;
                if (len >= want) begin
                    if (mode == hfs_pkg::STRAT_FIRST) begin
                        off = start;
                        return 1'b1;
                    end
                    if (!have || (mode == hfs_pkg::STRAT_BEST ?
                                  len <= pick_len : len >= pick_len)) begin
                        have = 1'b1;
                        pick_len = len;
                        off = start;
                    end
                end
            end
        end
        return have;
    endfunction

    function automatic t_alloc_result predict_alloc(input logic [SIZE_W-1:0] want);
        t_alloc_result res;
        int            n;
        int            off;
        int            run;
        logic          hit;
        n = (area_words < MAP_DEPTH) ? area_words : MAP_DEPTH;
        hit = 1'b0;
        off = 0;
        if (want != 0 && want <= n) begin
            if (fit_strategy == hfs_pkg::STRAT_NEXT) begin
                run = 0;
                for (int i = nf_ptr; i < n && !hit; i++) begin
                    if (heap_map[i]) begin
                        run = 0;
                    end else begin
                        run++;
                        if (run == want) begin
                            hit = 1'b1;
                            off = i + 1 - want;
                            nf_ptr = SIZE_W'(i + 1);
                        end
                    end
                end
                // nothing past the pointer: plain first fit, pointer stays
                if (!hit) hit = find_run(hfs_pkg::STRAT_FIRST, want, n, off);
            end else begin
                hit = find_run(fit_strategy, want, n, off);
            end
        end
        res.found = hit;
        res.addr = hit ? ADDR_W'(area_base + off) : 16'h0;
        return res;
    endfunction

    // monitor: results, config beats and input beats, all sampled at the rising edge
    always @(posedge i_clk) begin
        t_alloc_result exp_res;
        in_fire <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (alloc_expect_q.size() == 0) begin
                    report_mismatch("unexpected result beat", m_axis_tdata, 0);
                end else begin
                    exp_res = alloc_expect_q.pop_front();
                    if (m_axis_tuser !== exp_res.found)
                        report_mismatch("found", m_axis_tuser, exp_res.found);
                    if (m_axis_tdata !== exp_res.addr)
                        report_mismatch("alloc_address", m_axis_tdata, exp_res.addr);
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    hfs_pkg::CFG_STRATEGY:  fit_strategy = i_cfg_data[STRAT_W-1:0];
                    hfs_pkg::CFG_USE_START: area_base = i_cfg_data[ADDR_W-1:0];
                    hfs_pkg::CFG_USE_SIZE:  area_words = i_cfg_data[SIZE_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                accepted_cnt++;
                if (s_axis_tuser == hfs_pkg::KIND_WRITE)
                    heap_map[s_axis_tdata[IDX_W-1:0]] = s_axis_tdata[IDX_W];
                else
                    alloc_expect_q.push_back(predict_alloc(s_axis_tdata[IDX_W+SIZE_W:IDX_W+1]));
            end
        end
    end

    // input driver
    always @(negedge i_clk) begin
        t_heap_op op;
        if (!(s_axis_tvalid && !in_fire)) begin
            if (send_gap == 0 && !steady && $urandom_range(0, 7) == 0)
                send_gap = $urandom_range(1, 10);
            if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (op_pending_q.size() > 0) begin
                op = op_pending_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {2'b00, op.request_size, op.used_flag, op.map_index};
                s_axis_tuser <= op.kind;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(negedge i_clk) begin
        if (ready_gap == 0 && !steady && $urandom_range(0, 7) == 0)
            ready_gap = $urandom_range(1, 10);
        if (ready_gap > 0) begin
            ready_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic add_write(input int idx, input logic used);
        t_heap_op op;
        op.kind = hfs_pkg::KIND_WRITE;
        op.map_index = IDX_W'(idx);
        op.used_flag = used;
        op.request_size = SIZE_W'($urandom_range(0, 1024));
        op_pending_q.push_back(op);
        issued_cnt++;
    endtask

    task automatic add_search(input int want);
        t_heap_op op;
        op.kind = hfs_pkg::KIND_SEARCH;
        op.map_index = IDX_W'($urandom_range(0, 1023));
        op.used_flag = 1'($urandom_range(0, 1));
        op.request_size = SIZE_W'(want);
        op_pending_q.push_back(op);
        issued_cnt++;
    endtask

    // called at a falling edge, returns at one
    task automatic cfg_write(input logic [hfs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [hfs_pkg::CFG_DW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_area(input logic [STRAT_W-1:0] strat, input int base, input int words);
        cfg_write(hfs_pkg::CFG_STRATEGY, hfs_pkg::CFG_DW'(strat));
        cfg_write(hfs_pkg::CFG_USE_START, hfs_pkg::CFG_DW'(base));
        cfg_write(hfs_pkg::CFG_USE_SIZE, hfs_pkg::CFG_DW'(words));
        i_cfg_valid <= 1'b0;
    endtask

    // every beat taken and every result back, then a wait so that a trailing write lands
    task automatic drain();
        while (!(accepted_cnt == issued_cnt && alloc_expect_q.size() == 0))
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic random_phase(input int count, input int words);
        int n;
        int sel;
        n = (words < MAP_DEPTH) ? words : MAP_DEPTH;
        repeat (count) begin
            if ($urandom_range(0, 99) < 45) begin
                if ($urandom_range(0, 9) == 0)
                    add_write($urandom_range(0, 1023), $urandom_range(0, 99) < 40);
                else
                    add_write($urandom_range(0, n - 1), $urandom_range(0, 99) < 40);
            end else begin
                sel = $urandom_range(0, 19);
                if (sel == 0)
                    add_search(0);
                else if (sel == 1)
                    add_search(n < MAP_DEPTH ? $urandom_range(n + 1, 1024) : 1024);
                else if (sel == 2)
                    add_search(n);
                else if (sel <= 10)
                    add_search($urandom_range(1, n));
                else
                    add_search($urandom_range(1, (n + 3) / 4));
            end
        end
    endtask

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("TIMEOUT after %0d cycles", cycle_cnt);
        $display("Mismatches found");
        $finish;
    end

    initial begin
        logic [STRAT_W-1:0] strat_seq [4];
        int                 words;
        int                 base;
        strat_seq = '{hfs_pkg::STRAT_FIRST, hfs_pkg::STRAT_NEXT,
                      hfs_pkg::STRAT_BEST, hfs_pkg::STRAT_WORST};
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: first fit over the full map
        add_search(0);
        add_search(1024);
        add_write(0, 1'b1);
        add_write(1023, 1'b1);
        add_search(1024);
        add_search(1022);
        add_search(1);
        drain();

        // next fit, 16 entries, addresses wrap past 0xFFFF
        set_area(hfs_pkg::STRAT_NEXT, 16'hFFFC, 16);
        add_write(0, 1'b0);
        add_write(3, 1'b1);
        add_write(8, 1'b1);
        add_write(20, 1'b1);            // outside the area, never searched
        add_search(2);
        add_search(2);
        add_search(7);                  // leaves the pointer at the area end
        add_search(1);                  // falls back to first fit
        add_search(17);
        drain();

        set_area(hfs_pkg::STRAT_BEST, 16'h8000, 16);
        add_search(3);
        add_search(4);
        add_write(12, 1'b1);
        add_search(3);                  // tie between three runs of 3
        drain();

        // single-entry area
        set_area(hfs_pkg::STRAT_WORST, 16'h0000, 1);
        add_search(1);
        add_search(2);
        add_write(0, 1'b1);
        add_search(1);
        drain();

        for (int p = 0; p < 14; p++) begin
            if (p == 4 || p == 11)
                words = MAP_DEPTH;
            else if (p == 6)
                words = $urandom_range(1, 7);
            else
                words = $urandom_range(8, 64);
            base = (p == 0) ? 16'hFFFF : (p == 1) ? 16'h0000 : $urandom_range(0, 65535);
            if (p == 13) steady = 1'b1;
            set_area(p < 8 ? strat_seq[p % 4] : strat_seq[$urandom_range(0, 3)], base, words);
            random_phase(words == MAP_DEPTH ? 16 : 44, words);
            drain();
        end

        repeat (20) @(negedge i_clk);
        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== heap_fit_strategy_search.f =====
rtl/hfs_pkg.sv
rtl/heap_fit_strategy_search.sv
dv/tb_top.sv
